[rtl/tld_pkg.sv]
// Package: types and constants shared by the token lookup draft engine files.
package tld_pkg;

    localparam int TOKEN_W  = 16;
    localparam int POS_W    = 12;
    localparam int COUNT_W  = 5;
    localparam int OFFSET_W = 13;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 13'd8191;

    typedef enum logic [2:0] {
        OP_PROMPT = 3'd0,
        OP_FIRST  = 3'd1,
        OP_HEAD   = 3'd2,
        OP_ELEM   = 3'd3,
        OP_DRAFT  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [2:0]         operation;
        logic [TOKEN_W-1:0] token;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] draft_count;
        logic               last_element;
    } t_in;

    typedef struct packed {
        logic [TOKEN_W-1:0] drafted_token;
        logic               from_history;
        logic               last_of_run;
    } t_out;

endpackage

[rtl/token_lookup_draft_engine.sv]
// Top level: prompt-lookup draft engine with token history and last-seen table.
//
// Input channel (i_in_valid / o_in_stall / i_in) takes one transaction per item:
// prompt load, first-token load, commit head, commit element or draft.
// Output channel (o_out_valid / i_out_stall / o_out) returns drafted tokens.
// Loads and commits do not stall the input; the next item is accepted in the next cycle.
// A draft first reads the last-seen table, then the history RAM delivers one
// token per cycle into the output register while the receiver does not stall;
// the first result passes the table read register, the history read register
// and the output register. The single read port of the history RAM sets that
// rate. The input stalls until the last draft token is in the output register.
// When the receiver stalls, the output register holds its token and the
// history read data waits in the RAM read register; nothing is lost.
// After reset the last-seen table is cleared one entry a cycle, covering
// min(VOCAB_SIZE, 65536) entries (65536 by default); the input stalls during
// that pass. History length and commit state reset to zero.
module token_lookup_draft_engine
    import tld_pkg::*;
#(
    parameter int VOCAB_SIZE    = 65536,
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_DRAFT     = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int TBL_DEPTH = (VOCAB_SIZE > 65536) ? 65536 : VOCAB_SIZE;
    localparam int TAW       = $clog2(TBL_DEPTH);
    localparam int HAW       = $clog2(HISTORY_DEPTH);
    localparam int LW        = $clog2(HISTORY_DEPTH + 1);
    localparam int SW        = $clog2(HISTORY_DEPTH + MAX_DRAFT + 1);
    localparam int CW        = $clog2(MAX_DRAFT + 1);

    t_state              r_state, n_state;
    logic [TAW-1:0]      r_clr, n_clr;
    logic [LW-1:0]       r_len, n_len;
    logic [POS_W-1:0]    r_base, n_base;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [TOKEN_W-1:0]  r_tok, n_tok;
    logic [CW-1:0]       r_left, n_left;
    logic [SW-1:0]       r_src, n_src;
    logic                r_hit, n_hit;
    logic                r_found, n_found;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                t_we, t_re;
    logic [TAW-1:0]      t_waddr, t_raddr;
    logic [HAW:0]        t_wdata, t_rdata;
    logic                h_we, h_re;
    logic [HAW-1:0]      h_waddr, h_raddr;
    logic [TOKEN_W-1:0]  h_rdata;

    logic                in_acc, out_free, full, tok_ok, draft_go, lk_found;
    logic [CW-1:0]       cnt_sat;
    logic [SW-1:0]       src_next;
    logic [POS_W+1:0]    elem_pos;

    function automatic logic [HAW:0] rec_entry(input logic [31:0] p);
        logic [HAW:0] e;
        e = '0;
        if (p < 32'(HISTORY_DEPTH)) begin
            e = {1'b1, p[HAW-1:0]};
        end
        return e;
    endfunction

    tld_ram #(.WIDTH(HAW + 1), .DEPTH(TBL_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    tld_ram #(.WIDTH(TOKEN_W), .DEPTH(HISTORY_DEPTH)) u_history (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (i_in.token),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign full        = (r_len == LW'(HISTORY_DEPTH));
    assign tok_ok      = (32'(i_in.token) < 32'(VOCAB_SIZE));
    assign cnt_sat     = (32'(i_in.draft_count) > 32'(MAX_DRAFT)) ? CW'(MAX_DRAFT)
                                                                  : CW'(i_in.draft_count);
    assign draft_go    = in_acc && (i_in.operation == OP_DRAFT) && (cnt_sat != '0);
    assign lk_found    = (32'(r_tok) < 32'(VOCAB_SIZE)) && t_rdata[HAW];
    assign elem_pos    = (POS_W + 2)'(r_base) + (POS_W + 2)'(r_offset) + 1'b1;
    assign src_next    = (r_state == ST_LOOKUP) ? (SW'(t_rdata[HAW-1:0]) + 1'b1)
                                                : (r_src + 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == TAW'(TBL_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (draft_go) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free && (r_left == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory controls and datapath
    always_comb begin
        n_clr       = r_clr;
        n_len       = r_len;
        n_base      = r_base;
        n_offset    = r_offset;
        n_tok       = r_tok;
        n_left      = r_left;
        n_src       = r_src;
        n_hit       = r_hit;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        t_we        = 1'b0;
        t_waddr     = i_in.token[TAW-1:0];
        t_wdata     = '0;
        t_re        = 1'b0;
        t_raddr     = i_in.token[TAW-1:0];
        h_we        = 1'b0;
        h_waddr     = r_len[HAW-1:0];
        h_re        = 1'b0;
        h_raddr     = '0;

        case (r_state)
            ST_CLEAR: begin
                t_we    = 1'b1;
                t_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_in.operation))
                        OP_PROMPT: begin
                            h_we    = !full;
                            n_len   = full ? r_len : r_len + 1'b1;
                            t_we    = tok_ok;
                            t_wdata = full ? '0 : rec_entry(32'(r_len));
                        end
                        OP_FIRST: begin
                            h_we  = !full;
                            n_len = full ? r_len : r_len + 1'b1;
                        end
                        OP_HEAD: begin
                            t_we     = tok_ok;
                            t_wdata  = rec_entry(32'(i_in.position));
                            n_base   = i_in.position;
                            n_offset = '0;
                        end
                        OP_ELEM: begin
                            h_we  = !full;
                            n_len = full ? r_len : r_len + 1'b1;
                            if (i_in.last_element) begin
                                n_offset = '0;
                            end else begin
                                t_we     = tok_ok;
                                t_wdata  = rec_entry(32'(elem_pos));
                                n_offset = (r_offset == OFFSET_MAX) ? r_offset
                                                                    : r_offset + 1'b1;
                            end
                        end
                        OP_DRAFT: begin
                            t_re   = draft_go;
                            n_tok  = i_in.token;
                            n_left = cnt_sat;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                n_found = lk_found;
                n_hit   = lk_found && (32'(src_next) < 32'(r_len));
                n_src   = src_next;
                n_left  = r_left - 1'b1;
                h_re    = 1'b1;
                h_raddr = n_hit ? src_next[HAW-1:0] : '0;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.drafted_token = r_hit ? h_rdata : r_tok;
                    n_out.from_history  = r_hit;
                    n_out.last_of_run   = (r_left == '0);
                    if (r_left != '0) begin
                        n_hit   = r_found && (32'(src_next) < 32'(r_len));
                        n_src   = src_next;
                        n_left  = r_left - 1'b1;
                        h_re    = 1'b1;
                        h_raddr = n_hit ? src_next[HAW-1:0] : '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_len       <= '0;
            r_base      <= '0;
            r_offset    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_len       <= n_len;
            r_base      <= n_base;
            r_offset    <= n_offset;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok   <= n_tok;
        r_src   <= n_src;
        r_hit   <= n_hit;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/tld_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module tld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tld_checker.sv]
// Checker: port-level properties of the token lookup draft engine, bound to the top.
module tld_checker
    import tld_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open right after reset");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last_of_run |-> o_in_stall)
        else $error("input open inside a draft run");

    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out.last_of_run |=> o_out_valid)
        else $error("gap inside a draft run");

    a_draft_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.operation == OP_DRAFT)
            && (i_in.draft_count != '0) |=> o_in_stall)
        else $error("draft did not hold the input");

endmodule

bind token_lookup_draft_engine tld_checker u_tld_checker (.*);

[tb/sv/token_lookup_draft_engine_tb.sv]
// Testbench for the token lookup draft engine: directed and random traffic against a predictor.
module token_lookup_draft_engine_tb
    import tld_pkg::*;
();

    localparam int HIST_DEPTH    = 4096;
    localparam int VOCAB         = 65536;
    localparam int DRAFT_MAX     = 16;
    localparam int RANDOM_ITEMS  = 420;
    localparam int POOL_SIZE     = 24;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_LIMIT   = 40;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    token_lookup_draft_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [TOKEN_W-1:0] hist_mem [HIST_DEPTH];
    int unsigned        hist_len;
    bit                 seen_ok [VOCAB];
    int unsigned        seen_at [VOCAB];
    int unsigned        commit_base;
    int unsigned        commit_offset;

    t_out               drafts_due [$];
    logic [TOKEN_W-1:0] token_pool [POOL_SIZE];
    int                 mismatches;
    int                 cycle_count;
    int                 burst_left;
    int                 hold_request;
    int                 hold_left;
    int                 mode_left;
    t_stall_mode        stall_mode;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    function automatic void record_position(logic [TOKEN_W-1:0] tok, int unsigned p);
        if (p >= HIST_DEPTH) begin
            seen_ok[tok] = 1'b0;
            seen_at[tok] = 0;
        end else begin
            seen_ok[tok] = 1'b1;
            seen_at[tok] = p;
        end
    endfunction

    function automatic int unsigned append_history(logic [TOKEN_W-1:0] tok);
        int unsigned p;
        p = hist_len;
        if (p >= HIST_DEPTH) return HIST_DEPTH;
        hist_mem[p] = tok;
        hist_len = p + 1;
        return p;
    endfunction

    function automatic void track_and_draft(t_in item);
        int unsigned p;
        int unsigned cnt;
        int unsigned origin;
        int unsigned src;
        bit          found;
        t_out        res;
        case (item.operation)
            OP_PROMPT: begin
                p = append_history(item.token);
                record_position(item.token, p);
            end
            OP_FIRST: p = append_history(item.token);
            OP_HEAD: begin
                record_position(item.token, 32'(item.position));
                commit_base   = 32'(item.position);
                commit_offset = 0;
            end
            OP_ELEM: begin
                p = append_history(item.token);
                if (item.last_element) begin
                    commit_offset = 0;
                end else begin
                    record_position(item.token, commit_base + 1 + commit_offset);
                    if (commit_offset < OFFSET_MAX) commit_offset++;
                end
            end
            OP_DRAFT: begin
                cnt    = (item.draft_count > DRAFT_MAX) ? DRAFT_MAX : 32'(item.draft_count);
                found  = seen_ok[item.token];
                origin = found ? seen_at[item.token] : 0;
                for (int unsigned c = 1; c <= cnt; c++) begin
                    src = origin + c;
                    if (found && src < hist_len && src < HIST_DEPTH) begin
                        res.drafted_token = hist_mem[src];
                        res.from_history  = 1'b1;
                    end else begin
                        res.drafted_token = item.token;
                        res.from_history  = 1'b0;
                    end
                    res.last_of_run = (c == cnt);
                    drafts_due.insert(drafts_due.size(), res);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in make_item(logic [2:0] op, logic [TOKEN_W-1:0] tok,
                                      logic [POS_W-1:0] pos = '0,
                                      logic [COUNT_W-1:0] cnt = '0, logic last = 1'b0);
        t_in item;
        item.operation    = op;
        item.token        = tok;
        item.position     = pos;
        item.draft_count  = cnt;
        item.last_element = last;
        return item;
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_item(input t_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_and_draft(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (drafts_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [TOKEN_W-1:0] pick_token();
        if ($urandom_range(0, 3) != 0) return token_pool[$urandom_range(0, POOL_SIZE - 1)];
        return TOKEN_W'($urandom);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COUNT_W'(DRAFT_MAX);
            2:       return COUNT_W'($urandom_range(DRAFT_MAX + 1, (1 << COUNT_W) - 1));
            default: return COUNT_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_head_position();
        int unsigned hi;
        if ($urandom_range(0, 9) == 0) return POS_W'($urandom);
        hi = (hist_len > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : hist_len;
        return POS_W'($urandom_range(0, hi));
    endfunction

    task automatic test_prompt_and_draft();
        send_item(make_item(OP_PROMPT, 16'h0000, 12'hFFF));
        send_item(make_item(OP_PROMPT, 16'hFFFF));
        send_item(make_item(OP_PROMPT, 16'h1234));
        send_item(make_item(OP_FIRST,  16'hABCD));
        send_item(make_item(OP_PROMPT, 16'h0000));
        send_item(make_item(OP_PROMPT, 16'h5555));
        send_item(make_item(OP_DRAFT,  16'h0000, 12'h000, 5'd0));
        send_item(make_item(OP_DRAFT,  16'h0000, 12'hFFF, 5'd1));
        send_item(make_item(OP_DRAFT,  16'hFFFF, 12'h000, 5'd31));
        send_item(make_item(OP_DRAFT,  16'h1234, 12'h000, 5'd16));
        send_item(make_item(OP_DRAFT,  16'hABCD, 12'h000, 5'd3));
        send_item(make_item(OP_DRAFT,  16'h7777, 12'h000, 5'd2));
        wait_drained();
    endtask

    task automatic test_commit_run();
        send_item(make_item(OP_HEAD,  16'h0000, 12'd1));
        send_item(make_item(OP_ELEM,  16'h2222));
        send_item(make_item(OP_ELEM,  16'h3333, 12'h000, 5'd0, 1'b1));
        send_item(make_item(OP_DRAFT, 16'h2222, 12'h000, 5'd4));
        send_item(make_item(OP_DRAFT, 16'h0000, 12'h000, 5'd2));
        // element recorded one past the end of history reads as not found
        send_item(make_item(OP_HEAD,  16'h4444, 12'hFFF));
        send_item(make_item(OP_ELEM,  16'h4545));
        send_item(make_item(OP_ELEM,  16'h4646, 12'h000, 5'd0, 1'b1));
        send_item(make_item(OP_DRAFT, 16'h4444, 12'h000, 5'd2));
        send_item(make_item(OP_DRAFT, 16'h4545, 12'h000, 5'd2));
        wait_drained();
    endtask

    task automatic test_spare_opcodes();
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
            send_item(make_item(3'(c), 16'h0000, 12'hFFF, 5'd16, 1'b1));
        end
        send_item(make_item(OP_DRAFT, 16'h0000, 12'h000, 5'd3));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(2, 8);
                    repeat (n) send_item(make_item(OP_PROMPT, pick_token(), POS_W'($urandom)));
                    sent += n;
                end
                3: begin
                    send_item(make_item(OP_FIRST, pick_token(), POS_W'($urandom),
                                        COUNT_W'($urandom)));
                    sent++;
                end
                4, 5: begin
                    n = $urandom_range(1, 5);
                    send_item(make_item(OP_HEAD, pick_token(), pick_head_position(),
                                        COUNT_W'($urandom), 1'($urandom)));
                    repeat (n) send_item(make_item(OP_ELEM, pick_token(), POS_W'($urandom),
                                                   COUNT_W'($urandom), 1'b0));
                    // occasionally leave the commit run open
                    if ($urandom_range(0, 4) != 0) begin
                        send_item(make_item(OP_ELEM, pick_token(), POS_W'($urandom),
                                            COUNT_W'($urandom), 1'b1));
                        sent++;
                    end
                    sent += n + 1;
                end
                6, 7, 8: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_item(make_item(OP_DRAFT, pick_token(), POS_W'($urandom),
                                                   pick_count(), 1'($urandom)));
                    sent += n;
                end
                default: begin
                    send_item(make_item(3'($urandom), TOKEN_W'($urandom), POS_W'($urandom),
                                        COUNT_W'($urandom), 1'($urandom)));
                    sent++;
                end
            endcase
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        for (int i = 0; i < 12; i++) begin
            if (i % 4 == 3) begin
                send_item(make_item(OP_PROMPT, pick_token()));
            end else begin
                send_item(make_item(OP_DRAFT, token_pool[$urandom_range(0, POOL_SIZE - 1)],
                                    12'h000, 5'd16));
            end
        end
        wait_drained();
    endtask

    task automatic test_history_tail();
        logic [TOKEN_W-1:0] tail_tok;
        tail_tok = pick_token();
        // commit run straddling the end of the history depth
        send_item(make_item(OP_HEAD, token_pool[1], POS_W'(HIST_DEPTH - 3)));
        for (int i = 0; i < 4; i++) begin
            send_item(make_item(OP_ELEM, token_pool[2 + i]));
        end
        send_item(make_item(OP_ELEM, pick_token(), 12'h000, 5'd0, 1'b1));
        for (int i = 1; i < 6; i++) begin
            send_item(make_item(OP_DRAFT, token_pool[i], 12'h000, 5'd4));
        end
        // token seen at the end of history runs out at once
        send_item(make_item(OP_PROMPT, tail_tok));
        send_item(make_item(OP_DRAFT, tail_tok, 12'h000, 5'd16));
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(32, 160);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drafts_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result token %h", o_out.drafted_token));
            end else begin
                want = drafts_due.pop_front();
                if (o_out.drafted_token !== want.drafted_token)
                    report_mismatch($sformatf("drafted_token %h, want %h",
                                              o_out.drafted_token, want.drafted_token));
                if (o_out.from_history !== want.from_history)
                    report_mismatch($sformatf("from_history %b, want %b",
                                              o_out.from_history, want.from_history));
                if (o_out.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              o_out.last_of_run, want.last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) token_pool[i] = TOKEN_W'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_prompt_and_draft();
        test_commit_run();
        test_spare_opcodes();
        test_random_traffic();
        test_backpressure();
        test_history_tail();
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (drafts_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", drafts_due.size()));
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[token_lookup_draft_engine.f]
rtl/tld_pkg.sv
rtl/tld_ram.sv
rtl/token_lookup_draft_engine.sv
rtl/tld_checker.sv
tb/sv/token_lookup_draft_engine_tb.sv
